// ----- rtl/core/tcw_pkg.sv -----
// Shared types and constants for the text console writer.
// Used by text_console_writer; depends on nothing else.
package tcw_pkg;

    localparam int COLS   = 80;
    localparam int ROWS   = 25;
    localparam int CELLS  = COLS * ROWS;
    localparam int COL_W  = $clog2(COLS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int ADDR_W = $clog2(CELLS);

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_ATTR = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ERROR_ATTR  = 1'b1;

    localparam logic [7:0] CHAR_NL    = 8'h0A;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_ERR   = 8'h45;

    localparam logic [7:0] NORMAL_ATTR_RST = 8'h07;
    localparam logic [7:0] ERROR_ATTR_RST  = 8'h04;

    typedef enum logic [1:0] {
        MODE_PUT    = 2'd0,
        MODE_PUT_AT = 2'd1,
        MODE_READ   = 2'd2,
        MODE_CLEAR  = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_SCROLL_RD,
        S_SCROLL_WR,
        S_BLANK,
        S_CLEAR,
        S_DONE
    } state_t;

endpackage

// ----- rtl/core/text_console_writer.sv -----
// Text console writer: screen store, cursor and the sequencer that walks the store.
// Depends on tcw_pkg for sizes, codes and the state type.
//
// One item is taken at a time. A character write, positioned write or cell read
// goes from accept through the done state to the output register. A clear walks
// every cell; a write that scrolls copies the rows up and blanks the last row,
// since every cell goes through the single read and single write port of the
// screen memory, one copy per read-then-write pair. After reset the block runs a
// clearing pass over all CELLS cells before it takes its first item;
// configuration writes are taken throughout. A new item may be accepted while
// the previous result still waits on the output.
module text_console_writer (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [tcw_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                    cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    mode,
    input  logic [7:0]                    char_code,
    input  logic [7:0]                    attr,
    input  logic [7:0]                    col,
    input  logic [7:0]                    row,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [6:0]                    cursor_col,
    output logic [4:0]                    cursor_row,
    output logic [7:0]                    cell_char,
    output logic [7:0]                    cell_attr,
    output logic                          range_error,
    output logic                          scrolled
);

    localparam logic [tcw_pkg::ADDR_W-1:0] LAST_CELL =
        tcw_pkg::ADDR_W'(tcw_pkg::CELLS - 1);
    localparam logic [tcw_pkg::ADDR_W-1:0] LAST_COPY =
        tcw_pkg::ADDR_W'(tcw_pkg::CELLS - tcw_pkg::COLS - 1);

    tcw_pkg::state_t state_reg, state_next;

    logic [7:0]                   normal_attr_reg, error_attr_reg;
    logic [tcw_pkg::COL_W-1:0]    cur_col_reg, cur_col_next;
    logic [tcw_pkg::ROW_W-1:0]    cur_row_reg, cur_row_next;
    logic [tcw_pkg::ADDR_W-1:0]   idx_reg, idx_next;
    logic                         res_err_reg, res_err_next;
    logic                         res_scr_reg, res_scr_next;
    logic                         res_rd_reg, res_rd_next;

    logic                         out_valid_reg, out_valid_next;
    logic [tcw_pkg::COL_W-1:0]    out_col_reg, out_col_next;
    logic [tcw_pkg::ROW_W-1:0]    out_row_reg, out_row_next;
    logic [15:0]                  out_cell_reg, out_cell_next;
    logic                         out_err_reg, out_err_next;
    logic                         out_scr_reg, out_scr_next;

    logic [15:0]                  mem [tcw_pkg::CELLS];
    logic [15:0]                  rd_data_reg;
    logic                         mem_we, rd_en;
    logic [tcw_pkg::ADDR_W-1:0]   wr_addr, rd_addr;
    logic [15:0]                  wr_data;

    tcw_pkg::mode_t               item_mode;
    logic                         accept, out_free, outside;
    logic [tcw_pkg::COL_W-1:0]    tgt_col, put_col;
    logic [tcw_pkg::ROW_W-1:0]    tgt_row, put_row;
    logic [tcw_pkg::COL_W:0]      col_inc;
    logic [tcw_pkg::ROW_W:0]      row_inc;
    logic                         is_nl, wrap, put_scroll;
    logic [tcw_pkg::ADDR_W-1:0]   tgt_addr;
    logic [7:0]                   put_attr;

    // ---------------------------------------------------------------
    // Item decode and cursor arithmetic
    // ---------------------------------------------------------------
    assign item_mode = tcw_pkg::mode_t'(mode);
    assign accept    = in_valid && !in_stall;
    assign in_stall  = (state_reg != tcw_pkg::S_IDLE);
    assign out_free  = !out_valid_reg || !out_stall;

    assign outside = (col >= 8'(tcw_pkg::COLS)) || (row >= 8'(tcw_pkg::ROWS));

    // Mode 0 works at the cursor, modes 1 and 2 at the given position
    assign tgt_col = (item_mode == tcw_pkg::MODE_PUT) ? cur_col_reg
                                                      : col[tcw_pkg::COL_W-1:0];
    assign tgt_row = (item_mode == tcw_pkg::MODE_PUT) ? cur_row_reg
                                                      : row[tcw_pkg::ROW_W-1:0];
    assign tgt_addr = tcw_pkg::ADDR_W'(tgt_row) * tcw_pkg::ADDR_W'(tcw_pkg::COLS)
                    + tcw_pkg::ADDR_W'(tgt_col);

    assign is_nl      = (char_code == tcw_pkg::CHAR_NL);
    assign col_inc    = {1'b0, tgt_col} + 1'b1;
    assign row_inc    = {1'b0, tgt_row} + 1'b1;
    assign wrap       = is_nl || (col_inc == (tcw_pkg::COL_W + 1)'(tcw_pkg::COLS));
    assign put_scroll = wrap && (row_inc == (tcw_pkg::ROW_W + 1)'(tcw_pkg::ROWS));
    assign put_col    = wrap ? '0 : col_inc[tcw_pkg::COL_W-1:0];
    assign put_row    = !wrap      ? tgt_row :
                        put_scroll ? tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1) :
                                     row_inc[tcw_pkg::ROW_W-1:0];
    assign put_attr   = (attr == 8'd0) ? normal_attr_reg : attr;

    // ---------------------------------------------------------------
    // Sequencer: next state
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tcw_pkg::S_INIT:
            begin
                if (idx_reg == LAST_CELL)
                    state_next = tcw_pkg::S_IDLE;
            end
            tcw_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    unique case (item_mode)
                        tcw_pkg::MODE_PUT:
                            state_next = put_scroll ? tcw_pkg::S_SCROLL_RD : tcw_pkg::S_DONE;
                        tcw_pkg::MODE_PUT_AT:
                            state_next = (!outside && put_scroll) ? tcw_pkg::S_SCROLL_RD
                                                                  : tcw_pkg::S_DONE;
                        tcw_pkg::MODE_READ:
                            state_next = tcw_pkg::S_DONE;
                        tcw_pkg::MODE_CLEAR:
                            state_next = tcw_pkg::S_CLEAR;
                    endcase
                end
            end
            tcw_pkg::S_SCROLL_RD:
                state_next = tcw_pkg::S_SCROLL_WR;
            tcw_pkg::S_SCROLL_WR:
                state_next = (idx_reg == LAST_COPY) ? tcw_pkg::S_BLANK : tcw_pkg::S_SCROLL_RD;
            tcw_pkg::S_BLANK,
            tcw_pkg::S_CLEAR:
            begin
                if (idx_reg == LAST_CELL)
                    state_next = tcw_pkg::S_DONE;
            end
            tcw_pkg::S_DONE:
            begin
                if (out_free)
                    state_next = tcw_pkg::S_IDLE;
            end
            default:
                state_next = tcw_pkg::S_IDLE;
        endcase
    end

    // ---------------------------------------------------------------
    // Sequencer: memory controls
    // ---------------------------------------------------------------
    always_comb
    begin
        mem_we  = 1'b0;
        wr_addr = idx_reg;
        wr_data = 16'd0;
        rd_en   = 1'b0;
        rd_addr = tgt_addr;
        unique case (state_reg)
            tcw_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    unique case (item_mode)
                        tcw_pkg::MODE_PUT:
                        begin
                            mem_we  = !is_nl;
                            wr_addr = tgt_addr;
                            wr_data = {put_attr, char_code};
                        end
                        tcw_pkg::MODE_PUT_AT:
                        begin
                            mem_we  = outside || !is_nl;
                            wr_addr = outside ? LAST_CELL : tgt_addr;
                            wr_data = outside ? {error_attr_reg, tcw_pkg::CHAR_ERR}
                                              : {put_attr, char_code};
                        end
                        tcw_pkg::MODE_READ:
                            rd_en = !outside;
                        tcw_pkg::MODE_CLEAR:
                            mem_we = 1'b0;
                    endcase
                end
            end
            tcw_pkg::S_SCROLL_RD:
            begin
                rd_en   = 1'b1;
                rd_addr = idx_reg + tcw_pkg::ADDR_W'(tcw_pkg::COLS);
            end
            tcw_pkg::S_SCROLL_WR:
            begin
                mem_we  = 1'b1;
                wr_data = rd_data_reg;
            end
            tcw_pkg::S_INIT,
            tcw_pkg::S_BLANK:
                mem_we = 1'b1;
            tcw_pkg::S_CLEAR:
            begin
                mem_we  = 1'b1;
                wr_data = {normal_attr_reg, tcw_pkg::CHAR_SPACE};
            end
            tcw_pkg::S_DONE:
                mem_we = 1'b0;
            default:
                mem_we = 1'b0;
        endcase
    end

    // ---------------------------------------------------------------
    // Datapath next values
    // ---------------------------------------------------------------
    always_comb
    begin
        cur_col_next   = cur_col_reg;
        cur_row_next   = cur_row_reg;
        idx_next       = idx_reg;
        res_err_next   = res_err_reg;
        res_scr_next   = res_scr_reg;
        res_rd_next    = res_rd_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_col_next   = out_col_reg;
        out_row_next   = out_row_reg;
        out_cell_next  = out_cell_reg;
        out_err_next   = out_err_reg;
        out_scr_next   = out_scr_reg;

        unique case (state_reg)
            tcw_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    idx_next     = '0;
                    res_err_next = 1'b0;
                    res_scr_next = 1'b0;
                    res_rd_next  = 1'b0;
                    unique case (item_mode)
                        tcw_pkg::MODE_PUT:
                        begin
                            cur_col_next = put_col;
                            cur_row_next = put_row;
                            res_scr_next = put_scroll;
                        end
                        tcw_pkg::MODE_PUT_AT:
                        begin
                            res_err_next = outside;
                            if (!outside)
                            begin
                                cur_col_next = put_col;
                                cur_row_next = put_row;
                                res_scr_next = put_scroll;
                            end
                        end
                        tcw_pkg::MODE_READ:
                        begin
                            res_err_next = outside;
                            res_rd_next  = !outside;
                        end
                        tcw_pkg::MODE_CLEAR:
                        begin
                            cur_col_next = '0;
                            cur_row_next = '0;
                        end
                    endcase
                end
            end
            tcw_pkg::S_INIT,
            tcw_pkg::S_SCROLL_WR,
            tcw_pkg::S_BLANK,
            tcw_pkg::S_CLEAR:
                idx_next = idx_reg + 1'b1;
            tcw_pkg::S_SCROLL_RD:
                idx_next = idx_reg;
            tcw_pkg::S_DONE:
            begin
                // hand the result over once the output word is free
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_col_next   = cur_col_reg;
                    out_row_next   = cur_row_reg;
                    out_cell_next  = res_rd_reg ? rd_data_reg : 16'd0;
                    out_err_next   = res_err_reg;
                    out_scr_next   = res_scr_reg;
                end
            end
            default:
                idx_next = idx_reg;
        endcase
    end

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= tcw_pkg::S_INIT;
            idx_reg         <= '0;
            cur_col_reg     <= '0;
            cur_row_reg     <= '0;
            res_err_reg     <= 1'b0;
            res_scr_reg     <= 1'b0;
            res_rd_reg      <= 1'b0;
            out_valid_reg   <= 1'b0;
            normal_attr_reg <= tcw_pkg::NORMAL_ATTR_RST;
            error_attr_reg  <= tcw_pkg::ERROR_ATTR_RST;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            cur_col_reg   <= cur_col_next;
            cur_row_reg   <= cur_row_next;
            res_err_reg   <= res_err_next;
            res_scr_reg   <= res_scr_next;
            res_rd_reg    <= res_rd_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    tcw_pkg::CFG_NORMAL_ATTR: normal_attr_reg <= cfg_data;
                    tcw_pkg::CFG_ERROR_ATTR:  error_attr_reg  <= cfg_data;
                    default:                  normal_attr_reg <= normal_attr_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_col_reg  <= out_col_next;
        out_row_reg  <= out_row_next;
        out_cell_reg <= out_cell_next;
        out_err_reg  <= out_err_next;
        out_scr_reg  <= out_scr_next;
    end

    // Screen store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    assign out_valid   = out_valid_reg;
    assign cursor_col  = 7'(out_col_reg);
    assign cursor_row  = 5'(out_row_reg);
    assign cell_char   = out_cell_reg[7:0];
    assign cell_attr   = out_cell_reg[15:8];
    assign range_error = out_err_reg;
    assign scrolled    = out_scr_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_cursor_in_screen: assert property (@(posedge clk) disable iff (!rst_n)
        (cur_col_reg < tcw_pkg::COL_W'(tcw_pkg::COLS)) &&
        (cur_row_reg < tcw_pkg::ROW_W'(tcw_pkg::ROWS)))
        else $error("cursor left the screen");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == tcw_pkg::S_DONE))
        else $error("result loaded outside the done state");

    a_copy_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tcw_pkg::S_SCROLL_WR) |-> $past(state_reg == tcw_pkg::S_SCROLL_RD))
        else $error("scroll copy without a preceding read");

    a_blank_last_row: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tcw_pkg::S_BLANK) |-> (idx_reg > LAST_COPY))
        else $error("blanking outside the last row");

    a_scroll_leaves_last_row: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tcw_pkg::S_SCROLL_RD) |->
        (cur_row_reg == tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1)) && (cur_col_reg == '0))
        else $error("cursor not at start of last row during scroll");

endmodule
